>>> hw/rtl/afc_pkg.sv
`default_nettype none

package afc_pkg;

  // canvas geometry
  localparam int unsigned MaxWidth    = 64;
  localparam int unsigned MaxHeight   = 64;
  localparam int unsigned CanvasDepth = MaxWidth * MaxHeight;
  localparam int unsigned CanvasAddrW = $clog2(CanvasDepth);
  localparam int unsigned FillW       = CanvasAddrW + 1;

  // configuration port
  localparam int unsigned CfgW    = 7;
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned NpxW    = 2 * CfgW;

  localparam logic [CfgIdxW-1:0] CfgFrameWidth  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgFrameHeight = 1'b1;

  localparam logic [CfgW-1:0] FrameWidthReset  = 7'd64;
  localparam logic [CfgW-1:0] FrameHeightReset = 7'd64;

  // canvas word: red 7:0, green 15:8, blue 23:16, alpha 31:24
  localparam int unsigned PixW = 32;
  localparam logic [PixW-1:0] OpaqueWhite = '1;

  typedef struct packed {
    logic [7:0] src_red;
    logic [7:0] src_green;
    logic [7:0] src_blue;
    logic [7:0] src_alpha;
    logic       start_sequence;
  } src_pix_t;

  typedef struct packed {
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic [7:0] out_alpha;
    logic       frame_end;
  } res_pix_t;

  // old*(255-a) + new*a, rounded and divided by 255
  function automatic logic [7:0] mix_channel(input logic [7:0] a,
                                             input logic [7:0] old_v,
                                             input logic [7:0] new_v);
    logic [15:0] t;
    logic [15:0] u;
    t = 16'(16'(old_v) * 16'(8'd255 - a)) + 16'(16'(new_v) * 16'(a)) + 16'd128;
    u = t + {8'b0, t[15:8]};
    return u[15:8];
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/afc_if.sv
`default_nettype none

// incoming frame pixels
interface afc_src_if;
  logic               valid;
  logic               ready;
  afc_pkg::src_pix_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// composed canvas pixels
interface afc_res_if;
  logic               valid;
  logic               ready;
  afc_pkg::res_pix_t  data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/afc_ram.sv
`default_nettype none

module afc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 4096
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output      logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // registered read, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/alpha_frame_compositor.sv
// Alpha compositor: blends a stream of RGBA frame pixels over a canvas held
// in a single-port-write, single-port-read RAM, one word per pixel.
// Channels: pix_i takes source pixels in raster order (valid/ready), with
// start_sequence high on the first pixel of a new sequence; pix_o gives the
// composed canvas pixel and frame_end on the last pixel of each frame.
// The cfg port writes frame_width (index 0) and frame_height (index 1) and
// must only be used while no transaction is in flight.
// A pixel taken on pix_i passes the blend stage and the result register
// to pix_o. Throughput: one pixel per cycle unless pix_o stalls; the canvas
// RAM read at acceptance overlaps the write-back from the blend stage, and
// a read that meets the previous pixel's write to the same word is forwarded.
// Reset: no clearing pass is needed; a fill count marks the prefix of the
// canvas written since the last sequence start, and anything beyond it reads
// as opaque white. Reset and start_sequence both empty that prefix.
// Stalls: the result register holds while pix_o.ready is low; one more pixel
// may sit in the blend stage, after which pix_i.ready drops.
`default_nettype none

module alpha_frame_compositor (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          cfg_we_i,
  input  wire logic [afc_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  wire logic [afc_pkg::CfgW-1:0]      cfg_wdata_i,
  afc_src_if.sink                            pix_i,
  afc_res_if.source                          pix_o
);

  localparam int unsigned AddrW = afc_pkg::CanvasAddrW;
  localparam int unsigned FillW = afc_pkg::FillW;
  localparam int unsigned CfgW  = afc_pkg::CfgW;
  localparam int unsigned NpxW  = afc_pkg::NpxW;
  localparam int unsigned PixW  = afc_pkg::PixW;

  // configuration registers
  logic [CfgW-1:0] frame_width_q, frame_height_q;

  // position and written-prefix tracking
  logic [AddrW-1:0] pos_q, pos_d;
  logic [FillW-1:0] fill_q, fill_d;

  // blend stage
  logic                s1_valid_q, s1_valid_d;
  afc_pkg::src_pix_t   s1_pix_q;
  logic [AddrW-1:0]    s1_pos_q;
  logic                s1_last_q;
  logic                s1_white_q;
  logic                s1_hit_q;

  // last written word, for forwarding
  logic [PixW-1:0]     wb_data_q;
  logic [AddrW-1:0]    wb_addr_q;

  // result register
  logic                out_valid_q, out_valid_d;
  afc_pkg::res_pix_t   out_q, out_d;

  logic                in_acc, s1_adv;
  logic [CfgW-1:0]     w_eff, h_eff;
  logic [NpxW-1:0]     npx;
  logic [AddrW-1:0]    pos_base, pos_cur;
  logic [FillW-1:0]    fill_base;
  logic                start, last_cur, white_cur, hit_cur;
  logic [PixW-1:0]     rdata, old_word, new_word;

  // handshake
  assign s1_adv      = s1_valid_q && (!out_valid_q || pix_o.ready);
  assign pix_i.ready = !s1_valid_q || s1_adv;
  assign in_acc      = pix_i.valid && pix_i.ready;
  assign start       = pix_i.data.start_sequence;

  // effective frame size
  always_comb begin
    if (frame_width_q == '0) begin
      w_eff = CfgW'(1);
    end else if (32'(frame_width_q) > 32'(afc_pkg::MaxWidth)) begin
      w_eff = CfgW'(afc_pkg::MaxWidth);
    end else begin
      w_eff = frame_width_q;
    end
    if (frame_height_q == '0) begin
      h_eff = CfgW'(1);
    end else if (32'(frame_height_q) > 32'(afc_pkg::MaxHeight)) begin
      h_eff = CfgW'(afc_pkg::MaxHeight);
    end else begin
      h_eff = frame_height_q;
    end
    npx = NpxW'(w_eff) * NpxW'(h_eff);
  end

  // position of the incoming pixel and canvas bookkeeping
  always_comb begin
    pos_base  = start ? '0 : pos_q;
    pos_cur   = (32'(pos_base) >= 32'(npx)) ? '0 : pos_base;
    last_cur  = (32'(pos_cur) + 32'd1) == 32'(npx);
    fill_base = start ? '0 : fill_q;
    white_cur = start || (32'(pos_cur) >= 32'(fill_q));
    hit_cur   = !start && s1_valid_q && s1_adv && (s1_pos_q == pos_cur);
    pos_d     = pos_q;
    fill_d    = fill_q;
    if (in_acc) begin
      pos_d = last_cur ? '0 : pos_cur + AddrW'(1);
      if ((32'(pos_cur) + 32'd1) > 32'(fill_base)) begin
        fill_d = FillW'(pos_cur) + FillW'(1);
      end else begin
        fill_d = fill_base;
      end
    end
  end

  // canvas memory
  afc_ram #(
    .Width (PixW),
    .Depth (afc_pkg::CanvasDepth)
  ) u_canvas (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_pos_q),
    .wdata_i (new_word),
    .re_i    (in_acc),
    .raddr_i (pos_cur),
    .rdata_o (rdata)
  );

  // old canvas word: white beyond the written prefix, else forwarded or read
  always_comb begin
    if (s1_white_q) begin
      old_word = afc_pkg::OpaqueWhite;
    end else if (s1_hit_q) begin
      old_word = wb_data_q;
    end else begin
      old_word = rdata;
    end
  end

  // four blend lanes
  always_comb begin
    new_word[7:0]   = afc_pkg::mix_channel(s1_pix_q.src_alpha, old_word[7:0],
                                           s1_pix_q.src_red);
    new_word[15:8]  = afc_pkg::mix_channel(s1_pix_q.src_alpha, old_word[15:8],
                                           s1_pix_q.src_green);
    new_word[23:16] = afc_pkg::mix_channel(s1_pix_q.src_alpha, old_word[23:16],
                                           s1_pix_q.src_blue);
    new_word[31:24] = afc_pkg::mix_channel(s1_pix_q.src_alpha, old_word[31:24],
                                           s1_pix_q.src_alpha);
  end

  // stage valids and result payload
  always_comb begin
    s1_valid_d  = s1_valid_q;
    out_valid_d = out_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (pix_o.ready) begin
      out_valid_d = 1'b0;
    end
    out_d.out_red   = new_word[7:0];
    out_d.out_green = new_word[15:8];
    out_d.out_blue  = new_word[23:16];
    out_d.out_alpha = new_word[31:24];
    out_d.frame_end = s1_last_q;
  end

  assign pix_o.valid = out_valid_q;
  assign pix_o.data  = out_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= afc_pkg::FrameWidthReset;
      frame_height_q <= afc_pkg::FrameHeightReset;
      pos_q          <= '0;
      fill_q         <= '0;
      s1_valid_q     <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          afc_pkg::CfgFrameWidth:  frame_width_q  <= cfg_wdata_i;
          afc_pkg::CfgFrameHeight: frame_height_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      pos_q       <= pos_d;
      fill_q      <= fill_d;
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_pix_q   <= pix_i.data;
      s1_pos_q   <= pos_cur;
      s1_last_q  <= last_cur;
      s1_white_q <= white_cur;
      s1_hit_q   <= hit_cur;
    end
    if (s1_adv) begin
      wb_data_q <= new_word;
      wb_addr_q <= s1_pos_q;
      out_q     <= out_d;
    end
  end

  // forwarding only ever serves a word inside the written prefix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> !(s1_white_q && s1_hit_q))
    else $error("blend stage selects both white and forwarded word");

  // a forwarded word belongs to the same canvas position
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_hit_q) |-> (wb_addr_q == s1_pos_q))
    else $error("forwarded word from another canvas position");

  // the word being written lies inside the written prefix
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> (32'(s1_pos_q) < 32'(fill_q)))
    else $error("canvas write beyond fill count");

  // frame end marks the last raster position of the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && s1_last_q) |-> ((32'(s1_pos_q) + 32'd1) == 32'(npx)))
    else $error("frame end on a pixel that is not last in the frame");

endmodule

`default_nettype wire

>>> verif/alpha_frame_compositor_tb.sv
module alpha_frame_compositor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import afc_pkg::*;

  localparam int unsigned RandomItems = 1200;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned PrintLimit  = 50;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [CfgIdxW-1:0] cfg_idx;
  logic [CfgW-1:0]   cfg_wdata;

  afc_src_if src_if ();
  afc_res_if res_if ();

  alpha_frame_compositor DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .pix_i       (src_if),
    .pix_o       (res_if)
  );

  // shadow of the block: canvas, raster position and frame size registers
  logic [PixW-1:0]   canvas_shadow [CanvasDepth];
  int unsigned       raster_pos;
  logic [CfgW-1:0]   width_reg;
  logic [CfgW-1:0]   height_reg;

  // composed pixels still to come out, oldest first
  res_pix_t          composed_queue [$];

  int unsigned       mismatch_count = 0;
  int unsigned       pixels_sent;
  int unsigned       src_idle_pct;
  int unsigned       sink_stall_pct;
  int unsigned       quiet_cycles;

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // register value 0 counts as 1, anything above the maximum as the maximum
  function automatic int unsigned clamp_dim(input logic [CfgW-1:0] v, input int unsigned top);
    if (v == '0) return 1;
    if (int'(v) > top) return top;
    return v;
  endfunction

  // rounded divide by 255 of old*(255-a) + new*a
  function automatic logic [7:0] div255_blend(input logic [7:0] a, input logic [7:0] old_c,
                                              input logic [7:0] new_c);
    int unsigned t;
    t = int'(old_c) * (255 - int'(a)) + int'(new_c) * int'(a) + 128;
    return 8'(((t >> 8) + t) >> 8);
  endfunction

  function automatic void paint_canvas_white();
    foreach (canvas_shadow[i]) canvas_shadow[i] = OpaqueWhite;
  endfunction

  // blend one source pixel over the shadow canvas and advance the position
  function automatic res_pix_t compose_pixel(input src_pix_t p);
    int unsigned    npx;
    int unsigned    pos;
    logic [PixW-1:0] old_word;
    res_pix_t       r;
    npx = clamp_dim(width_reg, MaxWidth) * clamp_dim(height_reg, MaxHeight);
    if (p.start_sequence) begin
      paint_canvas_white();
      raster_pos = 0;
    end
    pos = (raster_pos >= npx) ? 0 : raster_pos;
    old_word = canvas_shadow[pos];
    r.out_red   = div255_blend(p.src_alpha, old_word[7:0], p.src_red);
    r.out_green = div255_blend(p.src_alpha, old_word[15:8], p.src_green);
    r.out_blue  = div255_blend(p.src_alpha, old_word[23:16], p.src_blue);
    r.out_alpha = div255_blend(p.src_alpha, old_word[31:24], p.src_alpha);
    canvas_shadow[pos] = {r.out_alpha, r.out_blue, r.out_green, r.out_red};
    r.frame_end = (pos + 1 == npx);
    raster_pos = r.frame_end ? 0 : pos + 1;
    return r;
  endfunction

  function automatic src_pix_t make_pixel(input logic [7:0] red, input logic [7:0] green,
                                          input logic [7:0] blue, input logic [7:0] alpha,
                                          input logic start);
    src_pix_t p;
    p.src_red        = red;
    p.src_green      = green;
    p.src_blue       = blue;
    p.src_alpha      = alpha;
    p.start_sequence = start;
    return p;
  endfunction

  // channel level with the extremes favoured
  function automatic logic [7:0] rand_level();
    case ($urandom_range(9))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic src_pix_t random_pixel(input logic start);
    logic [7:0] alpha;
    case ($urandom_range(7))
      0, 1: alpha = 8'd0;
      2, 3: alpha = 8'd255;
      default: alpha = 8'($urandom);
    endcase
    return make_pixel(rand_level(), rand_level(), rand_level(), alpha, start);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    if (mismatch_count <= PrintLimit)
      $display("%0t mismatch %s: got %0d expected %0d", $realtime, what, got, want);
  endtask

  // one source transaction, with random idle cycles in front of it
  task automatic send_pixel(input src_pix_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      src_if.valid <= 1'b0;
      @(posedge clk);
    end
    src_if.valid <= 1'b1;
    src_if.data  <= p;
    do @(posedge clk); while (!src_if.ready);
    composed_queue.push_back(compose_pixel(p));
    pixels_sent++;
  endtask

  // stop sending and wait for every composed pixel to come out
  task automatic drain_results();
    src_if.valid <= 1'b0;
    while (composed_queue.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_frame_size(input logic [CfgW-1:0] w, input logic [CfgW-1:0] h);
    cfg_we    <= 1'b1;
    cfg_idx   <= CfgFrameWidth;
    cfg_wdata <= w;
    @(posedge clk);
    width_reg = w;
    cfg_idx   <= CfgFrameHeight;
    cfg_wdata <= h;
    @(posedge clk);
    height_reg = h;
    cfg_we    <= 1'b0;
  endtask

  task automatic set_idling(input int unsigned src_pct, input int unsigned sink_pct);
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
  endtask

  // sizes from reset, fresh white canvas, alpha and colour extremes
  task automatic test_reset_state();
    set_idling(0, 0);
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd255, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd1, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd254, 1'b0));
    drain_results();
  endtask

  // 2x2 frames: frame end, blending over the previous frame, restart mid-frame
  task automatic test_frames_and_restart();
    set_frame_size(7'd2, 7'd2);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd255, 1'b1));
    send_pixel(make_pixel(8'd10, 8'd200, 8'd77, 8'd128, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd255, 8'd0, 1'b0));
    send_pixel(make_pixel(8'd1, 8'd2, 8'd3, 8'd64, 1'b0));
    send_pixel(make_pixel(8'd255, 8'd255, 8'd255, 8'd127, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd128, 8'd255, 8'd200, 1'b0));
    send_pixel(make_pixel(8'd90, 8'd90, 8'd90, 8'd255, 1'b0));
    send_pixel(make_pixel(8'd170, 8'd85, 8'd0, 8'd1, 1'b0));
    send_pixel(make_pixel(8'd33, 8'd66, 8'd99, 8'd150, 1'b0));
    send_pixel(make_pixel(8'd200, 8'd100, 8'd50, 8'd100, 1'b1));
    send_pixel(make_pixel(8'd7, 8'd8, 8'd9, 8'd0, 1'b0));
    drain_results();
  endtask

  // zero and oversized sizes, then a shrink that leaves the position past the frame
  task automatic test_size_limits();
    set_frame_size(7'd0, 7'd0);
    send_pixel(make_pixel(8'd12, 8'd34, 8'd56, 8'd78, 1'b0));
    send_pixel(make_pixel(8'd250, 8'd5, 8'd128, 8'd255, 1'b0));
    drain_results();
    set_frame_size(7'd127, 7'd127);
    send_pixel(make_pixel(8'd0, 8'd0, 8'd0, 8'd100, 1'b1));
    send_pixel(make_pixel(8'd255, 8'd0, 8'd0, 8'd200, 1'b0));
    send_pixel(make_pixel(8'd0, 8'd255, 8'd0, 8'd30, 1'b0));
    drain_results();
    set_frame_size(7'd2, 7'd1);
    send_pixel(make_pixel(8'd40, 8'd50, 8'd60, 8'd70, 1'b0));
    send_pixel(make_pixel(8'd80, 8'd90, 8'd100, 8'd110, 1'b0));
    drain_results();
  endtask

  // sender holds off until the pipeline is empty, then carries on
  task automatic test_pause_for_drain();
    int unsigned i;
    set_frame_size(7'd5, 7'd3);
    set_idling(20, 55);
    for (i = 0; i < 30; i++) send_pixel(random_pixel(i == 0));
    src_if.valid <= 1'b0;
    while (composed_queue.size() != 0) @(posedge clk);
    for (i = 0; i < 30; i++) send_pixel(random_pixel(1'b0));
    drain_results();
  endtask

  // sequences of whole frames at random sizes, with some broken ones
  task automatic test_random_sequences();
    int unsigned first_sent;
    int unsigned episode;
    int unsigned sel;
    int unsigned npx;
    int unsigned n_pix;
    int unsigned i;
    logic [CfgW-1:0] w_val;
    logic [CfgW-1:0] h_val;
    logic start;
    first_sent = pixels_sent;
    episode = 0;
    while (pixels_sent - first_sent < RandomItems) begin
      drain_results();
      sel = $urandom_range(99);
      if (sel < 70) begin
        w_val = 7'($urandom_range(1, 8));
        h_val = 7'($urandom_range(1, 8));
      end else if (sel < 80) begin
        w_val = 7'($urandom_range(1, 64));
        h_val = 7'($urandom_range(1, 2));
      end else if (sel < 85) begin
        w_val = 7'd1;
        h_val = 7'($urandom_range(1, 64));
      end else if (sel < 90) begin
        w_val = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(1, 6));
        h_val = ($urandom_range(1) == 0) ? 7'd0 : 7'($urandom_range(1, 6));
      end else if (sel < 95) begin
        w_val = 7'($urandom_range(65, 127));
        h_val = 7'($urandom_range(0, 2));
      end else begin
        w_val = ($urandom_range(1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
        h_val = ($urandom_range(1) == 0) ? 7'd64 : 7'($urandom_range(65, 127));
      end
      set_frame_size(w_val, h_val);
      case (episode % 4)
        0: set_idling(0, 0);
        1: set_idling(55, 0);
        2: set_idling(0, 55);
        default: set_idling(20, 20);
      endcase
      npx = clamp_dim(w_val, MaxWidth) * clamp_dim(h_val, MaxHeight);
      // big frames stay partial, the next size then wraps or continues
      if (npx > 128) n_pix = $urandom_range(1, 96);
      else n_pix = npx * $urandom_range(1, 3);
      if ($urandom_range(9) == 0) n_pix = $urandom_range(1, n_pix);
      for (i = 0; i < n_pix; i++) begin
        if (i == 0) start = ($urandom_range(99) < 85);
        else start = ($urandom_range(99) == 0);
        send_pixel(random_pixel(start));
      end
      episode++;
    end
    drain_results();
  endtask

  // receiver back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // compare each composed pixel with the oldest prediction
  always @(posedge clk) begin : check_results
    res_pix_t want;
    if (rst_n && res_if.valid && res_if.ready) begin
      if (composed_queue.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = composed_queue.pop_front();
        if (res_if.data.out_red !== want.out_red)
          report_mismatch("out_red", res_if.data.out_red, want.out_red);
        if (res_if.data.out_green !== want.out_green)
          report_mismatch("out_green", res_if.data.out_green, want.out_green);
        if (res_if.data.out_blue !== want.out_blue)
          report_mismatch("out_blue", res_if.data.out_blue, want.out_blue);
        if (res_if.data.out_alpha !== want.out_alpha)
          report_mismatch("out_alpha", res_if.data.out_alpha, want.out_alpha);
        if (res_if.data.frame_end !== want.frame_end)
          report_mismatch("frame_end", res_if.data.frame_end, want.frame_end);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (src_if.valid && src_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // reset and test sequence
  initial begin
    rst_n          <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_idx        <= CfgFrameWidth;
    cfg_wdata      <= '0;
    src_if.valid   <= 1'b0;
    src_if.data    <= '0;
    pixels_sent    = 0;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    raster_pos     = 0;
    width_reg      = FrameWidthReset;
    height_reg     = FrameHeightReset;
    paint_canvas_white();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_frames_and_restart();
    test_size_limits();
    test_pause_for_drain();
    test_random_sequences();

    drain_results();
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
